// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is asserted.
`define EIA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define EIA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/eia_pkg.sv =====
// Shared types and constants of the entity id allocator table.
// No dependencies.
`default_nettype none

package eia_pkg;

  localparam int OpW      = 3;
  localparam int EntityW  = 10;
  localparam int CompW    = 6;
  localparam int LayerW   = 16;
  localparam int MaskOutW = 64;
  localparam int StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_CREATE    = 3'd0,
    OP_DESTROY   = 3'd1,
    OP_COMP_ON   = 3'd2,
    OP_COMP_OFF  = 3'd3,
    OP_SET_LAYER = 3'd4,
    OP_READ      = 3'd5,
    OP_MAX_LAYER = 3'd6,
    OP_CLEAR     = 3'd7
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/eia_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module eia_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/entity_id_allocator_table.sv =====
// Entity id allocator table: entity state and free-id stack in two RAMs.
// Depends on eia_pkg, eia_ram and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid_i/in_ready_o | operation, entity, component, layer_value
//   out     | result    | out_valid_o/out_ready_i | entity_out, layer_out, is_active,
//           |           |                       | mask_out, status
//
// Table operations: RAM read on accept, then modify and write back in S_EXEC once the
// output register is free. Max layer and clear scan entries below high_water in S_SCAN,
// one entity RAM read per cycle, then give their result from S_EXEC. Reset clears
// control registers, not the RAMs; entries at or above high_water are never read as state.
// A result waits in the output register; a new request is taken meanwhile, and the
// write-back cycle stalls until the output register is free.
`default_nettype none
`include "assert_macros.svh"

module entity_id_allocator_table
  import eia_pkg::*;
#(
  parameter int MAX_ENTITIES = 1024,
  parameter int MASK_BITS    = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic [EntityW-1:0]  entity_i,
  input  wire logic [CompW-1:0]    component_i,
  input  wire logic [LayerW-1:0]   layer_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [EntityW-1:0]  entity_out_o,
  output logic      [LayerW-1:0]   layer_out_o,
  output logic                     is_active_o,
  output logic      [MaskOutW-1:0] mask_out_o,
  output logic      [StatusW-1:0]  status_o
);

  localparam int IdW     = $clog2(MAX_ENTITIES);
  localparam int CntW    = $clog2(MAX_ENTITIES + 1);
  localparam int CmpW    = (CntW > EntityW) ? CntW : EntityW;
  localparam int EntMemW = MASK_BITS + LayerW + 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTITIES);

  state_e                state_q, state_d;
  op_e                   op_q;
  logic [EntityW-1:0]    ent_q;
  logic [CompW-1:0]      comp_q;
  logic [LayerW-1:0]     lay_q;
  logic [CntW-1:0]       hw_q, hw_d;
  logic [CntW-1:0]       fc_q, fc_d;
  logic [CntW-1:0]       scan_idx_q, scan_idx_d;
  logic                  pend_q, pend_d;
  logic [IdW-1:0]        pend_idx_q, pend_idx_d;
  logic [LayerW-1:0]     max_q, max_d;

  logic                  out_valid_q, out_valid_d;
  logic [EntityW-1:0]    res_ent_q, res_ent_d;
  logic [LayerW-1:0]     res_layer_q, res_layer_d;
  logic                  res_active_q, res_active_d;
  logic [MaskOutW-1:0]   res_mask_q, res_mask_d;
  status_e               res_status_q, res_status_d;

  logic                  accept, slot_free, load_res;
  logic                  ent_we, ent_re;
  logic [IdW-1:0]        ent_waddr, ent_raddr;
  logic [EntMemW-1:0]    ent_wdata, ent_rdata;
  logic                  stk_we, stk_re;
  logic [IdW-1:0]        stk_waddr, stk_raddr;
  logic [IdW-1:0]        stk_wdata, stk_rdata;

  logic [MASK_BITS-1:0]  rd_mask, comp_bit;
  logic [LayerW-1:0]     rd_layer;
  logic                  rd_deact, allocated, live;
  logic [IdW-1:0]        ent_id, new_id;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign rd_mask   = ent_rdata[MASK_BITS-1:0];
  assign rd_layer  = ent_rdata[MASK_BITS +: LayerW];
  assign rd_deact  = ent_rdata[EntMemW-1];
  assign allocated = CmpW'(ent_q) < CmpW'(hw_q);
  assign live      = allocated && !rd_deact;
  assign ent_id    = IdW'(ent_q);
  assign comp_bit  = MASK_BITS'(1) << comp_q;

  assign stk_re    = accept && (op_e'(operation_i) == OP_CREATE) && (fc_q != '0);
  assign stk_raddr = IdW'(fc_q - CntW'(1));

  always_comb begin
    state_d      = state_q;
    hw_d         = hw_q;
    fc_d         = fc_q;
    scan_idx_d   = scan_idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    max_d        = max_q;
    load_res     = 1'b0;
    res_ent_d    = ent_q;
    res_layer_d  = '0;
    res_active_d = 1'b0;
    res_mask_d   = '0;
    res_status_d = STAT_OK;
    ent_re       = 1'b0;
    ent_raddr    = IdW'(entity_i);
    ent_we       = 1'b0;
    ent_waddr    = ent_id;
    ent_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = IdW'(fc_q);
    stk_wdata    = ent_id;
    new_id       = stk_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ent_re = 1'b1;
          if (op_e'(operation_i) == OP_MAX_LAYER || op_e'(operation_i) == OP_CLEAR) begin
            state_d    = S_SCAN;
            scan_idx_d = '0;
            pend_d     = 1'b0;
            max_d      = '0;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        if (pend_q) begin
          if (op_q == OP_MAX_LAYER) begin
            if (rd_layer > max_q) begin
              max_d = rd_layer;
            end
          end else if (!rd_deact) begin
            ent_we    = 1'b1;
            ent_waddr = pend_idx_q;
            ent_wdata = {1'b1, {LayerW{1'b0}}, {MASK_BITS{1'b0}}};
            if (fc_q < MaxCnt) begin
              stk_we    = 1'b1;
              stk_wdata = pend_idx_q;
              fc_d      = fc_q + CntW'(1);
            end
          end
        end
        ent_raddr = IdW'(scan_idx_q);
        if (scan_idx_q < hw_q) begin
          ent_re     = 1'b1;
          scan_idx_d = scan_idx_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = IdW'(scan_idx_q);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
          unique case (op_q)
            OP_CREATE: begin
              if (fc_q != '0) begin
                new_id = stk_rdata;
                fc_d   = fc_q - CntW'(1);
                ent_we = 1'b1;
              end else if (hw_q < MaxCnt) begin
                new_id = IdW'(hw_q);
                hw_d   = hw_q + CntW'(1);
                ent_we = 1'b1;
              end else begin
                res_status_d = STAT_FULL;
              end
              ent_waddr = new_id;
              ent_wdata = '0;
              res_ent_d = ent_we ? EntityW'(new_id) : '0;
            end
            OP_DESTROY: begin
              if (live) begin
                ent_we    = 1'b1;
                ent_wdata = {1'b1, {LayerW{1'b0}}, {MASK_BITS{1'b0}}};
                if (fc_q < MaxCnt) begin
                  stk_we = 1'b1;
                  fc_d   = fc_q + CntW'(1);
                end
              end else begin
                res_status_d = STAT_BAD;
              end
            end
            OP_COMP_ON, OP_COMP_OFF: begin
              if (live) begin
                ent_we    = 1'b1;
                ent_wdata = {1'b0, rd_layer,
                             (op_q == OP_COMP_ON) ? (rd_mask | comp_bit) : (rd_mask & ~comp_bit)};
              end else begin
                res_status_d = STAT_BAD;
              end
            end
            OP_SET_LAYER: begin
              if (live) begin
                ent_we    = 1'b1;
                ent_wdata = {1'b0, lay_q, rd_mask};
              end else begin
                res_status_d = STAT_BAD;
              end
            end
            OP_READ: begin
              if (allocated) begin
                res_layer_d  = rd_layer;
                res_mask_d   = MaskOutW'(rd_mask);
                res_active_d = !rd_deact;
              end
              if (!(allocated && !rd_deact)) begin
                res_status_d = STAT_BAD;
              end
            end
            OP_MAX_LAYER: begin
              res_layer_d = max_q;
            end
            OP_CLEAR: begin
              res_status_d = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      fc_q        <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      fc_q        <= fc_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    if (accept) begin
      op_q   <= op_e'(operation_i);
      ent_q  <= entity_i;
      comp_q <= component_i;
      lay_q  <= layer_value_i;
    end
    if (load_res) begin
      res_ent_q    <= res_ent_d;
      res_layer_q  <= res_layer_d;
      res_active_q <= res_active_d;
      res_mask_q   <= res_mask_d;
      res_status_q <= res_status_d;
    end
  end

  eia_ram #(
    .Width(EntMemW),
    .Depth(MAX_ENTITIES)
  ) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  eia_ram #(
    .Width(IdW),
    .Depth(MAX_ENTITIES)
  ) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign entity_out_o = res_ent_q;
  assign layer_out_o  = res_layer_q;
  assign is_active_o  = res_active_q;
  assign mask_out_o   = res_mask_q;
  assign status_o     = res_status_q;

  // free stack never holds more ids than have been handed out
  `EIA_ASSERT_ALWAYS(a_fc_le_hw, clk_i, !rst_ni || fc_q <= hw_q)
  `EIA_ASSERT(a_hw_monotonic, clk_i, rst_ni, 1'b1 |=> hw_q >= $past(hw_q))
  `EIA_ASSERT(a_ent_wr_allocated, clk_i, rst_ni, ent_we |-> CntW'(ent_waddr) <= hw_q)

endmodule

`default_nettype wire
